// File: rtl/saabb_pkg.sv
`timescale 1ns / 1ps
package saabb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FRAC_MAX      = 24;
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int REM_W         = DIFF_W + FRAC_MAX;
    localparam int Q_W           = 32;
    localparam int CMP_W         = DIFF_W + Q_W;
    localparam int FRAME_W       = 31;
    localparam int N_LANES       = 4;

    // divider lanes
    localparam int LANE_X_ENT = 0;
    localparam int LANE_X_EX  = 1;
    localparam int LANE_Y_ENT = 2;
    localparam int LANE_Y_EX  = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_min_x;
        logic signed [COORD_W-1:0] a_min_y;
        logic signed [COORD_W-1:0] a_max_x;
        logic signed [COORD_W-1:0] a_max_y;
        logic signed [COORD_W-1:0] b_min_x;
        logic signed [COORD_W-1:0] b_min_y;
        logic signed [COORD_W-1:0] b_max_x;
        logic signed [COORD_W-1:0] b_max_y;
        logic signed [COORD_W-1:0] a_vel_x;
        logic signed [COORD_W-1:0] a_vel_y;
        logic signed [COORD_W-1:0] b_vel_x;
        logic signed [COORD_W-1:0] b_vel_y;
    } box_item_t;

    typedef struct packed {
        logic hit;
    } hit_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_time;
    } cfg_item_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIFF_W-1:0] den;
        logic [Q_W-1:0]    quo;
        logic              neg;
    } lane_t;

    typedef struct packed {
        logic vzero;
        logic early;
        logic ent_en;
        logic ex_en;
        logic static_ok;
    } axis_ctl_t;

    typedef struct packed {
        axis_ctl_t x;
        axis_ctl_t y;
    } ctl_t;

    // magnitudes, sign and scaled dividend for one quotient
    function automatic lane_t div_prep(input logic signed [DIFF_W-1:0] num,
                                       input logic signed [DIFF_W-1:0] den,
                                       input int frac);
        lane_t             l;
        logic [DIFF_W-1:0] n_mag;
        logic [DIFF_W-1:0] d_mag;
        n_mag = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
        d_mag = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
        l.rem = REM_W'(n_mag) << frac;
        l.den = d_mag;
        l.quo = '0;
        l.neg = num[DIFF_W-1] ^ den[DIFF_W-1];
        return l;
    endfunction

    // one restoring step for quotient bit k; the top bit flags saturation
    function automatic lane_t div_step(input lane_t l, input int k);
        lane_t            r;
        logic [CMP_W-1:0] dsh;
        r   = l;
        dsh = CMP_W'(l.den) << k;
        if (CMP_W'(l.rem) >= dsh)
        begin
            r.rem = REM_W'(CMP_W'(l.rem) - dsh);
            r.quo = {l.quo[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.quo = {l.quo[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_time(input lane_t l);
        logic signed [Q_W-1:0] mag;
        mag = $signed({1'b0, l.quo[Q_W-2:0]});
        if (l.quo[Q_W-1])
            return l.neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        else
            return l.neg ? -mag : mag;
    endfunction

endpackage

// File: rtl/saabb_chan_if.sv
`timescale 1ns / 1ps
interface saabb_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/swept_aabb_collision_test_core.sv
`timescale 1ns / 1ps
// swept 2-d box test: one box pair with both velocities per item, one hit bit out
// channels: box_in (sink, box_item_t), hit_out (source, hit_item_t) and cfg
// (sink, cfg_item_t carrying frame_time), all valid/ready, moved at a clock
// edge where valid and ready are both high; cfg is always ready
// throughput: one item per cycle while hit_out is not stalled, with no bubbles between items
// pipeline: the accepting edge loads the operand prep register, then the
//   restoring divider stages (one quotient bit per stage, four dividers side by
//   side), then the saturation register, the x axis merge register and the y
//   axis merge into the output register
// the 32-stage divider sets the latency; every stage is a single compare/subtract
// stall: when the output register holds an item that hit_out does not take,
// the whole pipeline holds and box_in.ready drops; nothing is lost or repeated
// reset: all stage valid bits clear, frame_time returns to 0.016 in the
// configured fixed-point scale (1049 at 16 fraction bits)
// frame_time should only be written while no item is in flight
module swept_aabb_collision_test_core #(
    parameter int FRAC_BITS = saabb_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    saabb_chan_if.sink   box_in,
    saabb_chan_if.source hit_out,
    saabb_chan_if.sink   cfg
);
    import saabb_pkg::*;

    // 0.016 in the configured format, rounded
    localparam int FRAME_RESET = ((16 << FRAC_BITS) + 500) / 1000;

    // stage map: 0 prep, 1..N_DIV divide, S_SAT saturate, S_X, S_Y (output)
    localparam int N_DIV  = Q_W;
    localparam int S_SAT  = N_DIV + 1;
    localparam int S_X    = N_DIV + 2;
    localparam int S_Y    = N_DIV + 3;

    logic [FRAME_W-1:0] frame_time_reg;

    logic        valid_reg [0:S_Y];
    lane_t       lane_reg  [0:N_DIV][N_LANES];
    lane_t       lane_next [0:N_DIV][N_LANES];
    ctl_t        ctl_reg   [0:S_X];
    ctl_t        ctl_next;

    logic signed [Q_W-1:0] t_reg [N_LANES];

    // state after the x axis
    logic signed [Q_W-1:0] tf_reg, tf_next;
    logic signed [Q_W-1:0] tl_reg, tl_next;
    logic                  x_ok_reg, x_ok_next;
    logic signed [Q_W-1:0] ty_ent_reg, ty_ex_reg;

    logic hit_reg, hit_next;
    logic adv;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_time_reg <= FRAME_W'(FRAME_RESET);
        else if (cfg.valid)
            frame_time_reg <= cfg.data.frame_time;
    end

    // ---------------- handshake ----------------
    // the pipeline moves whenever the output register is free or being taken
    assign adv           = !valid_reg[S_Y] || hit_out.ready;
    assign box_in.ready  = adv;
    assign hit_out.valid = valid_reg[S_Y];
    assign hit_out.data  = '{hit: hit_reg};

    // ---------------- operand prep ----------------
    logic signed [DIFF_W-1:0] d1x, d2x, d1y, d2y, vx, vy;

    always_comb
    begin
        // d1 = amax - bmin, d2 = amin - bmax, v = vel_b - vel_a
        d1x = DIFF_W'(box_in.data.a_max_x) - DIFF_W'(box_in.data.b_min_x);
        d2x = DIFF_W'(box_in.data.a_min_x) - DIFF_W'(box_in.data.b_max_x);
        d1y = DIFF_W'(box_in.data.a_max_y) - DIFF_W'(box_in.data.b_min_y);
        d2y = DIFF_W'(box_in.data.a_min_y) - DIFF_W'(box_in.data.b_max_y);
        vx  = DIFF_W'(box_in.data.b_vel_x) - DIFF_W'(box_in.data.a_vel_x);
        vy  = DIFF_W'(box_in.data.b_vel_y) - DIFF_W'(box_in.data.a_vel_y);

        // moving in negative direction: entry from d1, exit from d2; else swapped
        ctl_next.x.vzero     = (vx == '0);
        ctl_next.x.early     = vx[DIFF_W-1] ? (d2x > 0) : (d1x < 0);
        ctl_next.x.ent_en    = vx[DIFF_W-1] ? (d1x < 0) : (d2x > 0);
        ctl_next.x.ex_en     = vx[DIFF_W-1] ? (d2x < 0) : (d1x > 0);
        ctl_next.x.static_ok = !((d1x < 0) || (d2x > 0));
        ctl_next.y.vzero     = (vy == '0);
        ctl_next.y.early     = vy[DIFF_W-1] ? (d2y > 0) : (d1y < 0);
        ctl_next.y.ent_en    = vy[DIFF_W-1] ? (d1y < 0) : (d2y > 0);
        ctl_next.y.ex_en     = vy[DIFF_W-1] ? (d2y < 0) : (d1y > 0);
        ctl_next.y.static_ok = !((d1y < 0) || (d2y > 0));

        // a zero velocity lane divides by zero; its result is never used
        lane_next[0][LANE_X_ENT] = div_prep(vx[DIFF_W-1] ? d1x : d2x, vx, FRAC_BITS);
        lane_next[0][LANE_X_EX]  = div_prep(vx[DIFF_W-1] ? d2x : d1x, vx, FRAC_BITS);
        lane_next[0][LANE_Y_ENT] = div_prep(vy[DIFF_W-1] ? d1y : d2y, vy, FRAC_BITS);
        lane_next[0][LANE_Y_EX]  = div_prep(vy[DIFF_W-1] ? d2y : d1y, vy, FRAC_BITS);

        // ---------------- divider stages ----------------
        // stage s resolves quotient bit (Q_W - s); the first one is the overflow flag
        for (int s = 1; s <= N_DIV; s++)
        begin
            for (int i = 0; i < N_LANES; i++)
            begin
                lane_next[s][i] = div_step(lane_reg[s-1][i], Q_W - s);
            end
        end
    end

    // ---------------- axis merge ----------------
    logic signed [Q_W-1:0] tf_y, tl_y;
    logic                  y_ok;

    always_comb
    begin
        // x axis starts from entry 0 and exit frame_time
        tf_next   = '0;
        tl_next   = $signed({1'b0, frame_time_reg});
        x_ok_next = ctl_reg[S_SAT].x.static_ok;
        if (!ctl_reg[S_SAT].x.vzero)
        begin
            if (ctl_reg[S_SAT].x.ent_en && (t_reg[LANE_X_ENT] > tf_next))
                tf_next = t_reg[LANE_X_ENT];
            if (ctl_reg[S_SAT].x.ex_en && (t_reg[LANE_X_EX] < tl_next))
                tl_next = t_reg[LANE_X_EX];
            x_ok_next = !ctl_reg[S_SAT].x.early && (tf_next <= tl_next);
        end

        // y axis continues from the x window
        tf_y = tf_reg;
        tl_y = tl_reg;
        y_ok = ctl_reg[S_X].y.static_ok;
        if (!ctl_reg[S_X].y.vzero)
        begin
            if (ctl_reg[S_X].y.ent_en && (ty_ent_reg > tf_y))
                tf_y = ty_ent_reg;
            if (ctl_reg[S_X].y.ex_en && (ty_ex_reg < tl_y))
                tl_y = ty_ex_reg;
            y_ok = !ctl_reg[S_X].y.early && (tf_y <= tl_y);
        end

        hit_next = !(ctl_reg[S_X].x.vzero && ctl_reg[S_X].y.vzero) && x_ok_reg && y_ok;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= S_Y; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= box_in.valid;
            for (int s = 1; s <= S_Y; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= N_DIV; s++)
            begin
                for (int i = 0; i < N_LANES; i++)
                begin
                    lane_reg[s][i] <= lane_next[s][i];
                end
            end
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s <= S_X; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            for (int i = 0; i < N_LANES; i++)
            begin
                t_reg[i] <= sat_time(lane_reg[N_DIV][i]);
            end
            tf_reg     <= tf_next;
            tl_reg     <= tl_next;
            x_ok_reg   <= x_ok_next;
            ty_ent_reg <= t_reg[LANE_Y_ENT];
            ty_ex_reg  <= t_reg[LANE_Y_EX];
            hit_reg    <= hit_next;
        end
    end

`ifndef SYNTHESIS
    // a held result freezes the whole pipeline and blocks new items
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S_Y] && !hit_out.ready) |-> !box_in.ready)
        else $error("input taken while output stalled");

    // an accepted item shows up in the prep stage next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (box_in.valid && box_in.ready) |=> valid_reg[0])
        else $error("accepted item lost at prep stage");

    // frame_time only changes by a configuration write
    a_frame_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> $stable(frame_time_reg))
        else $error("frame_time changed without write");

    // both relative velocities zero never reports a hit
    a_no_hit_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_reg[S_X] && ctl_reg[S_X].x.vzero && ctl_reg[S_X].y.vzero)
        |=> !hit_reg)
        else $error("hit reported with zero relative velocity");
`endif

endmodule

// File: tb/saabb_hit_checker.sv
`timescale 1ns / 1ps
module saabb_hit_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     box_fire,
    input  saabb_pkg::box_item_t     box_data,
    input  logic                     hit_fire,
    input  saabb_pkg::hit_item_t     hit_data,
    input  logic                     cfg_fire,
    input  saabb_pkg::cfg_item_t     cfg_data,
    output int                       fail_count,
    output int                       pending
);
    import saabb_pkg::*;

    localparam int FB = 16;

    logic [FRAME_W-1:0] sweep_window;
    logic               hit_queue[$];

    assign pending = hit_queue.size();

    // signed q division, truncated toward zero, saturated to 32 bits
    function automatic longint time_div(input longint num, input longint den);
        logic           neg;
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? longint'(-num) : longint'(num);
        d = (den < 0) ? longint'(-den) : longint'(den);
        q = (n << FB) / d;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return longint'(q);
    endfunction

    // one axis; false when a hit is ruled out
    function automatic logic axis_sweep(input longint amin, input longint amax,
                                        input longint bmin, input longint bmax,
                                        input longint v, inout longint t_in,
                                        inout longint t_out);
        longint t;
        if (v < 0)
        begin
            if (amin > bmax)
                return 1'b0;
            if (amax < bmin)
            begin
                t = time_div(amax - bmin, v);
                if (t > t_in)
                    t_in = t;
            end
            if (amin < bmax)
            begin
                t = time_div(amin - bmax, v);
                if (t < t_out)
                    t_out = t;
            end
            return t_in <= t_out;
        end
        if (v > 0)
        begin
            if (amin > bmax)
            begin
                t = time_div(amin - bmax, v);
                if (t > t_in)
                    t_in = t;
            end
            if (amax > bmin)
            begin
                t = time_div(amax - bmin, v);
                if (t < t_out)
                    t_out = t;
            end
            if (amax < bmin)
                return 1'b0;
            return t_in <= t_out;
        end
        return !(amax < bmin || amin > bmax);
    endfunction

    function automatic logic predict_hit(input box_item_t b);
        longint vx;
        longint vy;
        longint t_in;
        longint t_out;
        vx = longint'(b.b_vel_x) - longint'(b.a_vel_x);
        vy = longint'(b.b_vel_y) - longint'(b.a_vel_y);
        t_in = 0;
        t_out = longint'({33'b0, sweep_window});
        if (vx == 0 && vy == 0)
            return 1'b0;
        if (!axis_sweep(b.a_min_x, b.a_max_x, b.b_min_x, b.b_max_x, vx, t_in, t_out))
            return 1'b0;
        return axis_sweep(b.a_min_y, b.a_max_y, b.b_min_y, b.b_max_y, vy, t_in, t_out);
    endfunction

    task automatic report(input string msg);
        $display("checker mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_window <= FRAME_W'(1049);
        end
        else
        begin
            if (cfg_fire)
                sweep_window <= cfg_data.frame_time;
            if (box_fire)
                hit_queue.push_back(predict_hit(box_data));
            if (hit_fire)
            begin
                if (hit_queue.size() == 0)
                    report("hit item with nothing expected");
                else if (hit_queue.pop_front() !== hit_data.hit)
                    report($sformatf("hit was %b, expected the opposite", hit_data.hit));
            end
        end
    end
endmodule

// File: tb/swept_aabb_collision_test_core_test.sv
`timescale 1ns / 1ps
module swept_aabb_collision_test_core_test;
    import saabb_pkg::*;

    localparam int LATENCY = 36;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic gaps_on;

    saabb_chan_if #(.T(box_item_t)) box_in ();
    saabb_chan_if #(.T(hit_item_t)) hit_out ();
    saabb_chan_if #(.T(cfg_item_t)) cfg ();

    always #4 clk = ~clk;

    swept_aabb_collision_test_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .box_in (box_in.sink),
        .hit_out(hit_out.source),
        .cfg    (cfg.sink)
    );

    saabb_hit_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_fire  (box_in.valid && box_in.ready),
        .box_data  (box_in.data),
        .hit_fire  (hit_out.valid && hit_out.ready),
        .hit_data  (hit_out.data),
        .cfg_fire  (cfg.valid && cfg.ready),
        .cfg_data  (cfg.data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        box_in.valid = 1'b0;
        box_in.data = '0;
        hit_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        gaps_on = 1'b1;
    end

    // receiver: random stall bursts while gaps are on
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 10);
                hit_out.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            hit_out.ready <= 1'b1;
        end
    end

    // random 32-bit value, often small so boxes actually meet
    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
        endcase
    endfunction

    function automatic box_item_t rnd_pair();
        box_item_t b;
        logic [31:0] w;
        b = '{default: '0};
        b.a_min_x = rnd_coord();
        b.a_min_y = rnd_coord();
        b.b_min_x = rnd_coord();
        b.b_min_y = rnd_coord();
        // mostly well-formed boxes, a few with corners swapped or wild
        if ($urandom_range(0, 9) != 0)
        begin
            w = $urandom_range(0, 8 << 16);
            b.a_max_x = b.a_min_x + w;
            w = $urandom_range(0, 8 << 16);
            b.a_max_y = b.a_min_y + w;
            w = $urandom_range(0, 8 << 16);
            b.b_max_x = b.b_min_x + w;
            w = $urandom_range(0, 8 << 16);
            b.b_max_y = b.b_min_y + w;
        end
        else
        begin
            b.a_max_x = rnd_coord();
            b.a_max_y = rnd_coord();
            b.b_max_x = rnd_coord();
            b.b_max_y = rnd_coord();
        end
        b.a_vel_x = rnd_coord();
        b.a_vel_y = rnd_coord();
        b.b_vel_x = $urandom_range(0, 7) == 0 ? b.a_vel_x : rnd_coord();
        b.b_vel_y = $urandom_range(0, 7) == 0 ? b.a_vel_y : rnd_coord();
        // velocities scaled to the frame so entry times land in range
        if ($urandom_range(0, 1))
        begin
            b.b_vel_x = b.a_vel_x + 32'($signed($urandom_range(0, 8000 << 16))
                        - (4000 << 16));
            b.b_vel_y = b.a_vel_y + 32'($signed($urandom_range(0, 8000 << 16))
                        - (4000 << 16));
        end
        return b;
    endfunction

    // one box item, with optional idle burst ahead of it
    task automatic send_pair(input box_item_t b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            box_in.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        box_in.valid <= 1'b1;
        box_in.data <= b;
        do
            @(posedge clk);
        while (!box_in.ready);
    endtask

    // drop valid, then wait for the pipeline to drain
    task automatic drain();
        box_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_window(input logic [FRAME_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data <= cfg_item_t'(v);
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic box_item_t mk(input int amnx, input int amxx, input int bmnx,
                                     input int bmxx, input int vx, input int vy);
        box_item_t b;
        b = '{default: '0};
        b.a_min_x = amnx;
        b.a_max_x = amxx;
        b.b_min_x = bmnx;
        b.b_max_x = bmxx;
        b.a_max_y = 32'h0001_0000;
        b.b_max_y = 32'h0001_0000;
        b.b_vel_x = vx;
        b.b_vel_y = vy;
        return b;
    endfunction

    initial
    begin
        box_item_t b;
        int        k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default window, overlap with no relative motion, touching
        // edges, approaching, receding, malformed corners, field extremes
        send_pair(mk(0, 1 << 16, 0, 1 << 16, 0, 0));
        send_pair(mk(0, 1 << 16, 1 << 16, 2 << 16, 0, 1));
        send_pair(mk(0, 1 << 16, 2 << 16, 3 << 16, -(200 << 16), 0));
        send_pair(mk(0, 1 << 16, 2 << 16, 3 << 16, 200 << 16, 0));
        send_pair(mk(2 << 16, 3 << 16, 0, 1 << 16, 200 << 16, 0));
        send_pair(mk(2 << 16, 3 << 16, 0, 1 << 16, -(200 << 16), 0));
        send_pair(mk(3 << 16, 0, 1 << 16, 2 << 16, 5 << 16, 0));
        send_pair(mk(0, 1 << 16, 1 << 16, 0, -(5 << 16), 3));
        b = '{default: 32'h8000_0000};
        send_pair(b);
        b = '{default: 32'h7FFF_FFFF};
        send_pair(b);
        b = '{default: 32'hFFFF_FFFF};
        send_pair(b);
        b = mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        b.a_vel_x = 32'h7FFF_FFFF;
        b.b_vel_x = 32'h8000_0000;
        send_pair(b);
        b.a_vel_x = 32'h8000_0000;
        b.b_vel_x = 32'h7FFF_FFFF;
        send_pair(b);
        send_pair(mk(0, 1 << 16, 1 << 16, 2 << 16, 1, 0));
        drain();

        // directed at the window extremes
        write_window('0);
        send_pair(mk(0, 1 << 16, 0, 1 << 16, 1 << 16, 0));
        send_pair(mk(0, 1 << 16, 2 << 16, 3 << 16, -(1 << 16), 0));
        drain();
        write_window({FRAME_W{1'b1}});
        send_pair(mk(0, 1 << 16, 2 << 16, 3 << 16, -1, 0));
        send_pair(mk(0, 1 << 16, 2 << 16, 3 << 16, 1, 0));
        drain();

        // random phases through several windows; the drain is the full pause
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_window(FRAME_W'(1049));
                1: write_window(FRAME_W'(1));
                2: write_window(FRAME_W'(1 << 16));
                3: write_window(FRAME_W'($urandom));
                4: write_window({FRAME_W{1'b1}});
                default: write_window(FRAME_W'(1049));
            endcase
            if (phase == 5)
                gaps_on = 1'b0;
            k = (phase == 5) ? 300 : 310;
            for (int i = 0; i < k; i++)
                send_pair(rnd_pair());
            drain();
        end

        if (fail_count == 0)
            $display("swept_aabb_collision_test_core_test: PASS");
        else
            $display("swept_aabb_collision_test_core_test: FAIL");
        $finish;
    end

    // overall watchdog
    initial
    begin
        #5ms;
        $display("swept_aabb_collision_test_core_test: FAIL");
        $finish;
    end
endmodule
